FILE: hw/rtl/ipv6p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6p_pkg
// Types and constants shared by the IPv6 text address parser modules.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

  localparam int GROUP_COUNT = 8;
  localparam int GROUP_W     = 16;
  localparam int GROUP_IDX_W = 3;

  localparam logic [7:0] CHAR_COLON   = 8'h3a;
  localparam logic [7:0] CHAR_DOT     = 8'h2e;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  // Subtracting this from 'a'..'f' gives the values 10..15.
  localparam logic [7:0] LETTER_BIAS  = 8'h57;

  localparam logic [11:0] OCTET_MAX    = 12'd255;
  localparam logic [2:0]  MAX_DIGITS   = 3'd4;
  localparam logic [1:0]  FULL_DOTS    = 2'd3;
  localparam logic [3:0]  MAX_HEX_GRPS = 4'd7;
  localparam logic [3:0]  MAX_PRE_TAIL = 4'd6;
  localparam logic [3:0]  ALL_GROUPS   = 4'd8;
  localparam logic [31:0] BCAST_TAIL   = 32'hffff_ffff;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        parse_ok;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  groups_done;
    logic [3:0]  gap_position;
    logic        gap_seen;
    logic [15:0] hex_acc;
    logic [2:0]  digit_count;
    logic [7:0]  dec_acc;
    logic        dec_bad;
    logic        quad_mode;
    logic [1:0]  dot_count;
    logic [23:0] quad_prefix;
    logic        colon_seen;
    logic        at_start;
    logic        error_flag;
  } parse_state_t;

  typedef struct packed {
    logic                   en;
    logic [GROUP_IDX_W-1:0] idx;
    logic [GROUP_W-1:0]     data;
  } group_wr_t;

  typedef logic [GROUP_COUNT-1:0][GROUP_W-1:0] group_array_t;

  localparam parse_state_t PARSE_RESET = '{
    groups_done:  4'd0,
    gap_position: 4'd0,
    gap_seen:     1'b0,
    hex_acc:      16'd0,
    digit_count:  3'd0,
    dec_acc:      8'd0,
    dec_bad:      1'b0,
    quad_mode:    1'b0,
    dot_count:    2'd0,
    quad_prefix:  24'd0,
    colon_seen:   1'b0,
    at_start:     1'b1,
    error_flag:   1'b0
  };

endpackage

FILE: hw/rtl/ipv6_text_address_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser
// Parses IPv6 address text, one character per word, into a 128-bit address
// with '::' expanded and an ok flag given on the last character.
//
//   Channel  Ports                          Word
//   input    in_valid / in_ready / in_word   one character plus last mark
//   output   out_valid / out_ready / out_word address halves plus ok flag
//
// One character is taken every cycle unless a last character is held by a
// stalled result; a result passes the input register, then the result register.
// The parser state update and the gap expansion are one combinational path
// between those registers. Reset clears the parser state and both valids;
// the group storage holds no reset value. A stalled result only holds back
// a last character waiting in the input register; other characters go on.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser
  import ipv6p_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic         s1_valid_r;
  in_word_t     s1_word_r;
  logic         s1_fire;
  logic         out_free;
  logic         out_valid_r;
  out_word_t    out_word_r;
  parse_state_t state_r;
  parse_state_t state_step;
  parse_state_t state_nxt;
  group_wr_t    group_wr;
  group_array_t groups_nxt;
  out_word_t    result;

  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_word_r.last_char || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  ipv6p_step u_step (
    .char_code (s1_word_r.char_code),
    .state_cur (state_r),
    .state_nxt (state_step),
    .group_wr  (group_wr)
  );

  ipv6p_groups u_groups (
    .clk        (clk),
    .commit     (s1_fire),
    .group_wr   (group_wr),
    .groups_nxt (groups_nxt)
  );

  ipv6p_finish u_finish (
    .state_fin (state_step),
    .groups    (groups_nxt),
    .result    (result)
  );

  // The last character closes the address and starts the next one fresh.
  assign state_nxt = s1_word_r.last_char ? PARSE_RESET : state_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= PARSE_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        state_r <= state_nxt;
      end
      if (s1_fire && s1_word_r.last_char) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word_r <= in_word;
    end
    if (s1_fire && s1_word_r.last_char) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A failed parse never shows a nonzero address.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.parse_ok |->
      out_word_r.addr_high == 64'd0 && out_word_r.addr_low == 64'd0)
    else $error("failed parse with nonzero address");

  // A character that is not the last never waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_word_r.last_char |-> s1_fire)
    else $error("non-final character stalled");

  // After a last character the parser is back at the start of an address.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_word_r.last_char |=> state_r.at_start && !state_r.error_flag)
    else $error("parser state not cleared after last character");

  // The error flag stays set until the address ends.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.error_flag && !(s1_fire && s1_word_r.last_char) |=> state_r.error_flag)
    else $error("error flag dropped inside an address");

  // Group count never passes eight.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.groups_done <= ALL_GROUPS)
    else $error("group count overflow");

endmodule

FILE: hw/rtl/ipv6p_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6p_step
// Next-state logic of the parser for one character: hex groups, '::',
// dotted-quad tail and the sticky error flag.
// ----------------------------------------------------------------------------
module ipv6p_step
  import ipv6p_pkg::*;
(
  input  logic [7:0]   char_code,
  input  parse_state_t state_cur,
  output parse_state_t state_nxt,
  output group_wr_t    group_wr
);

  logic        do_hex;
  logic        do_quad;
  logic        is_digit;
  logic        is_letter;
  logic [7:0]  lower_char;
  logic [3:0]  digit_val;
  logic [3:0]  letter_val;
  logic [11:0] dec_sum;
  logic [3:0]  groups_inc;

  always_comb begin
    lower_char = char_code | CASE_BIT;
    is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    is_letter  = (lower_char >= CHAR_LOWER_A) && (lower_char <= CHAR_LOWER_F);
    digit_val  = char_code[3:0];
    letter_val = 4'(lower_char - LETTER_BIAS);
    // dec_acc * 10 + digit, as shifts and adds.
    dec_sum    = (12'(state_cur.dec_acc) << 3) + (12'(state_cur.dec_acc) << 1)
               + 12'(digit_val);
    groups_inc = state_cur.groups_done + 4'd1;

    state_nxt     = state_cur;
    group_wr.en   = 1'b0;
    group_wr.idx  = state_cur.groups_done[GROUP_IDX_W-1:0];
    group_wr.data = state_cur.hex_acc;
    do_hex        = 1'b0;
    do_quad       = 1'b0;

    // A leading colon is dropped; the following ':' then opens a gap.
    if (state_cur.at_start) begin
      state_nxt.at_start = 1'b0;
      do_hex = (char_code != CHAR_COLON);
    end else if (!state_cur.error_flag) begin
      do_quad = state_cur.quad_mode;
      do_hex  = !state_cur.quad_mode;
    end

    if (do_quad) begin
      if (is_digit) begin
        if (dec_sum > OCTET_MAX) begin
          state_nxt.error_flag = 1'b1;
        end else begin
          state_nxt.dec_acc = dec_sum[7:0];
        end
      end else if (char_code == CHAR_DOT) begin
        if (state_cur.dot_count == FULL_DOTS) begin
          state_nxt.error_flag = 1'b1;
        end else begin
          state_nxt.quad_prefix = {state_cur.quad_prefix[15:0], state_cur.dec_acc};
          state_nxt.dot_count   = state_cur.dot_count + 2'd1;
          state_nxt.dec_acc     = 8'd0;
        end
      end else begin
        state_nxt.error_flag = 1'b1;
      end
    end

    if (do_hex) begin
      if (char_code == CHAR_COLON) begin
        if (state_cur.digit_count != 3'd0) begin
          group_wr.en = 1'b1;
          state_nxt.groups_done = groups_inc;
          if (groups_inc >= ALL_GROUPS) begin
            state_nxt.error_flag = 1'b1;
          end else begin
            state_nxt.hex_acc     = 16'd0;
            state_nxt.digit_count = 3'd0;
            state_nxt.dec_acc     = 8'd0;
            state_nxt.dec_bad     = 1'b0;
            state_nxt.colon_seen  = 1'b1;
          end
        end else if (!state_cur.gap_seen) begin
          state_nxt.gap_seen     = 1'b1;
          state_nxt.gap_position = state_cur.groups_done;
          state_nxt.colon_seen   = 1'b1;
        end else begin
          state_nxt.error_flag = 1'b1;
        end
      end else if (char_code == CHAR_DOT && state_cur.digit_count != 3'd0) begin
        // The group just read turns out to be the first tail octet.
        if (state_cur.groups_done >= MAX_HEX_GRPS || !state_cur.colon_seen ||
            state_cur.dec_bad) begin
          state_nxt.error_flag = 1'b1;
        end else begin
          state_nxt.quad_mode   = 1'b1;
          state_nxt.quad_prefix = 24'(state_cur.dec_acc);
          state_nxt.dot_count   = 2'd1;
          state_nxt.dec_acc     = 8'd0;
        end
      end else if (state_cur.digit_count >= MAX_DIGITS) begin
        state_nxt.error_flag = 1'b1;
      end else begin
        state_nxt.digit_count = state_cur.digit_count + 3'd1;
        if (is_digit) begin
          state_nxt.hex_acc = {state_cur.hex_acc[11:0], digit_val};
          if (dec_sum > OCTET_MAX) begin
            state_nxt.dec_bad = 1'b1;
          end else begin
            state_nxt.dec_acc = dec_sum[7:0];
          end
        end else if (is_letter) begin
          state_nxt.hex_acc = {state_cur.hex_acc[11:0], letter_val};
          state_nxt.dec_bad = 1'b1;
        end else begin
          state_nxt.error_flag = 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/ipv6p_groups.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6p_groups
// Storage for the finished 16-bit groups, with a view that already holds
// the write of the character being taken.
// ----------------------------------------------------------------------------
module ipv6p_groups
  import ipv6p_pkg::*;
(
  input  logic         clk,
  input  logic         commit,
  input  group_wr_t    group_wr,
  output group_array_t groups_nxt
);

  group_array_t groups_r;

  always_comb begin
    groups_nxt = groups_r;
    if (group_wr.en) begin
      groups_nxt[group_wr.idx] = group_wr.data;
    end
  end

  // Entries are only read after being written for the current address.
  always_ff @(posedge clk) begin
    if (commit) begin
      groups_r <= groups_nxt;
    end
  end

endmodule

FILE: hw/rtl/ipv6p_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6p_finish
// Final checks and '::' zero expansion that build the 128-bit address.
// ----------------------------------------------------------------------------
module ipv6p_finish
  import ipv6p_pkg::*;
(
  input  parse_state_t state_fin,
  input  group_array_t groups,
  output out_word_t    result
);

  logic [31:0]  tail;
  logic [3:0]   total;
  logic [3:0]   shift;
  logic [4:0]   gap_end;
  logic         form_ok;
  logic         fit_ok;
  logic         ok;
  group_array_t tmp;
  group_array_t grp;
  logic [GROUP_COUNT-1:0][GROUP_IDX_W-1:0] src_idx;

  always_comb begin
    tail  = {state_fin.quad_prefix, state_fin.dec_acc};
    total = state_fin.groups_done + (state_fin.quad_mode ? 4'd2 : 4'd1);
    shift = ALL_GROUPS - total;

    // Stored groups, then the open group or the two tail groups.
    for (int j = 0; j < GROUP_COUNT; j++) begin
      if (4'(j) < state_fin.groups_done) begin
        tmp[j] = groups[j];
      end else if (4'(j) == state_fin.groups_done) begin
        tmp[j] = state_fin.quad_mode ? tail[31:16] : state_fin.hex_acc;
      end else if (4'(j) == state_fin.groups_done + 4'd1 && state_fin.quad_mode) begin
        tmp[j] = tail[15:0];
      end else begin
        tmp[j] = '0;
      end
    end

    if (state_fin.quad_mode) begin
      form_ok = (state_fin.dot_count == FULL_DOTS) && (tail != BCAST_TAIL) &&
                (state_fin.groups_done <= MAX_PRE_TAIL);
    end else begin
      form_ok = (state_fin.digit_count != 3'd0 || state_fin.gap_seen) &&
                (state_fin.groups_done <= MAX_HEX_GRPS);
    end

    if (total == ALL_GROUPS) begin
      fit_ok = !state_fin.gap_seen;
    end else begin
      fit_ok = state_fin.gap_seen && (state_fin.gap_position <= total);
    end

    ok = !state_fin.error_flag && form_ok && fit_ok;

    // Groups after the gap move up by the number of zero groups inserted.
    gap_end = 5'(state_fin.gap_position) + 5'(shift);
    for (int k = 0; k < GROUP_COUNT; k++) begin
      src_idx[k] = GROUP_IDX_W'(4'(k) - shift);
      if (4'(k) < state_fin.gap_position) begin
        grp[k] = tmp[k];
      end else if (5'(k) >= gap_end) begin
        grp[k] = tmp[src_idx[k]];
      end else begin
        grp[k] = '0;
      end
    end

    result.parse_ok  = ok;
    result.addr_high = ok ? {grp[0], grp[1], grp[2], grp[3]} : 64'd0;
    result.addr_low  = ok ? {grp[4], grp[5], grp[6], grp[7]} : 64'd0;
  end

endmodule

FILE: tb/sv/ipv6_text_address_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_test
// Self-checking bench for the IPv6 text parser. Address texts go in one
// character per word; each last character must give one address word.
// Each result is checked against the typed word of its table row, if any,
// else against a bit-true parser kept in the bench. A short table of
// hand-picked texts runs first. Random well-formed, corrupted and noise
// texts follow under three idling profiles, with one long output stall.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_test;
  import ipv6p_pkg::*;

  localparam int NUM_ROWS         = 25;
  localparam int CHARS_PER_PHASE  = 400;
  localparam int LONG_STALL       = 300;
  localparam int WATCHDOG_LIMIT   = 3000;

  localparam out_word_t REJECTED = '{addr_high: 64'd0, addr_low: 64'd0, parse_ok: 1'b0};

  typedef struct {
    string     text;
    bit        typed;
    out_word_t word;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  ipv6_text_address_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Bench copy of the parser state.
  logic [15:0] grp_mem [0:7];
  logic [3:0]  n_groups;
  logic [3:0]  gap_at;
  logic        have_gap;
  logic [15:0] hex_val;
  logic [2:0]  n_digits;
  logic [7:0]  dec_val;
  logic        not_octet;
  logic        in_tail;
  logic [1:0]  n_dots;
  logic [23:0] tail_bytes;
  logic        saw_colon;
  logic        first_char;
  logic        bad_syntax;

  out_word_t   addr_q [$];
  row_t        given_q [$];
  logic [7:0]  text_q [$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_asked;
  string       text_chars = "0123456789abcdefABCDEF:.:.g";

  row_t dir_rows [NUM_ROWS] = '{
    '{"::", 1'b1, '{64'd0, 64'd0, 1'b1}},
    '{":", 1'b1, REJECTED},
    '{"1:2:3:4:5:6:7:8", 1'b1,
      '{64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 1'b1}},
    '{"ffff:ffff:ffff:ffff:ffff:ffff:ffff:ffff", 1'b1, '{'1, '1, 1'b1}},
    '{"FFFF::", 1'b1, '{64'hffff_0000_0000_0000, 64'd0, 1'b1}},
    '{"::ffff:1.2.3.4", 1'b1, '{64'd0, 64'h0000_ffff_0102_0304, 1'b1}},
    '{"::255.255.255.255", 1'b1, REJECTED},
    '{"::255.255.255.254", 1'b1, '{64'd0, 64'h0000_0000_ffff_fffe, 1'b1}},
    '{"::1.2.3.256", 1'b1, REJECTED},
    '{"::1.2.3", 1'b1, REJECTED},
    '{"::1.2.3.4.5", 1'b1, REJECTED},
    '{"12345::", 1'b1, REJECTED},
    '{"1:2:3:4:5:6:7:8:9", 1'b1, REJECTED},
    '{"1:2:3:4:5:6:7::", 1'b1, REJECTED},
    '{"1:2:3", 1'b1, REJECTED},
    '{"1.2.3.4", 1'b1, REJECTED},
    '{"::a.2.3.4", 1'b1, REJECTED},
    '{"1::2::3", 1'b1, REJECTED},
    '{"::g", 1'b1, REJECTED},
    '{"1:2:3:4:5:6:7:1.2.3.4", 1'b1, REJECTED},
    '{"::300.1.2.3", 1'b1, REJECTED},
    '{"1:2:3:4:5:6:1.2.3.4", 1'b0, REJECTED},
    '{"fe80::1", 1'b0, REJECTED},
    '{"::1..2.", 1'b0, REJECTED},
    '{":1:2:3:4:5:6:7:8", 1'b0, REJECTED}
  };

  function automatic void clear_parser();
    for (int i = 0; i < 8; i++) grp_mem[i] = 16'd0;
    n_groups   = 4'd0;
    gap_at     = 4'd0;
    have_gap   = 1'b0;
    hex_val    = 16'd0;
    n_digits   = 3'd0;
    dec_val    = 8'd0;
    not_octet  = 1'b0;
    in_tail    = 1'b0;
    n_dots     = 2'd0;
    tail_bytes = 24'd0;
    saw_colon  = 1'b0;
    first_char = 1'b1;
    bad_syntax = 1'b0;
  endfunction

  function automatic void feed_hex_char(input logic [7:0] c);
    int unsigned dec_next;
    logic [7:0]  lc;
    lc = c | CASE_BIT;
    if (c == CHAR_COLON) begin
      if (n_digits != 3'd0) begin
        grp_mem[n_groups[2:0]] = hex_val;
        n_groups = n_groups + 4'd1;
        if (n_groups >= ALL_GROUPS) begin
          bad_syntax = 1'b1;
        end else begin
          hex_val   = 16'd0;
          n_digits  = 3'd0;
          dec_val   = 8'd0;
          not_octet = 1'b0;
          saw_colon = 1'b1;
        end
      end else if (!have_gap) begin
        have_gap  = 1'b1;
        gap_at    = n_groups;
        saw_colon = 1'b1;
      end else begin
        bad_syntax = 1'b1;
      end
    end else if (c == CHAR_DOT && n_digits != 3'd0) begin
      if (n_groups >= MAX_HEX_GRPS || !saw_colon || not_octet) begin
        bad_syntax = 1'b1;
      end else begin
        in_tail    = 1'b1;
        tail_bytes = {16'd0, dec_val};
        n_dots     = 2'd1;
        dec_val    = 8'd0;
      end
    end else if (n_digits >= MAX_DIGITS) begin
      bad_syntax = 1'b1;
    end else begin
      n_digits = n_digits + 3'd1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        hex_val  = {hex_val[11:0], c[3:0]};
        dec_next = dec_val * 10 + c[3:0];
        if (dec_next > OCTET_MAX) not_octet = 1'b1;
        else dec_val = dec_next[7:0];
      end else if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_F) begin
        // Lowercase letters carry their value minus nine in the low nibble.
        hex_val   = {hex_val[11:0], lc[3:0] + 4'd9};
        not_octet = 1'b1;
      end else begin
        bad_syntax = 1'b1;
      end
    end
  endfunction

  // Advances the parser by one character; returns 1 when an address word
  // is due and leaves it in res.
  function automatic bit parse_char(input logic [7:0] c, input logic last,
                                    output out_word_t res);
    int unsigned dec_next;
    int          total;
    logic [15:0] tmp [0:7];
    logic [15:0] fin [0:7];
    logic [31:0] tail32;
    bit          good;
    res = REJECTED;
    if (first_char) begin
      first_char = 1'b0;
      if (c != CHAR_COLON) feed_hex_char(c);
    end else if (!bad_syntax) begin
      if (!in_tail) begin
        feed_hex_char(c);
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        dec_next = dec_val * 10 + c[3:0];
        if (dec_next > OCTET_MAX) bad_syntax = 1'b1;
        else dec_val = dec_next[7:0];
      end else if (c == CHAR_DOT) begin
        if (n_dots >= FULL_DOTS) begin
          bad_syntax = 1'b1;
        end else begin
          tail_bytes = {tail_bytes[15:0], dec_val};
          n_dots     = n_dots + 2'd1;
          dec_val    = 8'd0;
        end
      end else begin
        bad_syntax = 1'b1;
      end
    end
    if (!last) return 1'b0;

    for (int i = 0; i < 8; i++) begin
      tmp[i] = grp_mem[i];
      fin[i] = 16'd0;
    end
    total = int'(n_groups);
    good  = !bad_syntax;
    if (good) begin
      if (in_tail) begin
        tail32 = {tail_bytes, dec_val};
        if (n_dots != FULL_DOTS || tail32 == BCAST_TAIL || total > MAX_PRE_TAIL) begin
          good = 1'b0;
        end else begin
          tmp[total]     = tail32[31:16];
          tmp[total + 1] = tail32[15:0];
          total          = total + 2;
        end
      end else if ((n_digits == 3'd0 && !have_gap) || total > MAX_HEX_GRPS) begin
        good = 1'b0;
      end else begin
        tmp[total] = hex_val;
        total      = total + 1;
      end
    end
    if (good) begin
      if (total == ALL_GROUPS) begin
        if (have_gap) good = 1'b0;
        else for (int i = 0; i < 8; i++) fin[i] = tmp[i];
      end else if (!have_gap || gap_at > total) begin
        good = 1'b0;
      end else begin
        // Groups after the gap slide to the end of the address.
        for (int i = 0; i < total; i++) begin
          if (i < gap_at) fin[i] = tmp[i];
          else fin[(i + 8 - total) % 8] = tmp[i];
        end
      end
    end
    if (good) begin
      res.addr_high = {fin[0], fin[1], fin[2], fin[3]};
      res.addr_low  = {fin[4], fin[5], fin[6], fin[7]};
      res.parse_ok  = 1'b1;
    end
    clear_parser();
    return 1'b1;
  endfunction

  // Results are checked before the incoming word is predicted, so the
  // order within one edge is fixed.
  always @(posedge clk) begin : scoreboard
    out_word_t want;
    out_word_t got;
    row_t      row;
    if (rst_n && out_valid && out_ready) begin
      got = out_word;
      if (addr_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word expected none, got %h", $time, got);
      end else begin
        want = addr_q.pop_front();
        if (got.addr_high !== want.addr_high) begin
          mismatch_count++;
          $display("%0t: addr_high expected %h, got %h", $time, want.addr_high,
                   got.addr_high);
        end
        if (got.addr_low !== want.addr_low) begin
          mismatch_count++;
          $display("%0t: addr_low expected %h, got %h", $time, want.addr_low,
                   got.addr_low);
        end
        if (got.parse_ok !== want.parse_ok) begin
          mismatch_count++;
          $display("%0t: parse_ok expected %b, got %b", $time, want.parse_ok,
                   got.parse_ok);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      if (parse_char(in_word.char_code, in_word.last_char, want)) begin
        if (given_q.size() != 0) begin
          row = given_q.pop_front();
          if (row.typed) want = row.word;
        end
        addr_q.push_back(want);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int stall_served;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_served != stall_asked) begin
        stall_served = stall_asked;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] pick_char();
    if ($urandom_range(1) == 0) return text_chars[$urandom_range(0, text_chars.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_group();
    int v;
    repeat ($urandom_range(1, 4)) begin
      v = $urandom_range(0, 15);
      if (v < 10) text_q.push_back(8'(CHAR_ZERO + v));
      else if ($urandom_range(1) == 0) text_q.push_back(8'(CHAR_LOWER_A + v - 10));
      else text_q.push_back(8'((CHAR_LOWER_A ^ CASE_BIT) + v - 10));
    end
  endtask

  // Fills the text queue with a well-formed address of random shape.
  task automatic build_address();
    bit    tail;
    bit    gap;
    int    slots;
    int    k;
    int    left;
    string s;
    text_q = {};
    tail  = ($urandom_range(0, 9) < 3);
    gap   = ($urandom_range(0, 9) < 6);
    slots = tail ? 6 : 8;
    k     = $urandom_range(0, slots - 1);
    left  = $urandom_range(0, k);
    if ($urandom_range(0, 9) == 0 && !(gap && left == 0)) text_q.push_back(CHAR_COLON);
    if (gap) begin
      for (int i = 0; i < left; i++) begin
        push_group();
        text_q.push_back(CHAR_COLON);
      end
      if (left == 0) text_q.push_back(CHAR_COLON);
      text_q.push_back(CHAR_COLON);
      for (int i = 0; i < k - left; i++) begin
        if (i > 0) text_q.push_back(CHAR_COLON);
        push_group();
      end
      if (tail && k > left) text_q.push_back(CHAR_COLON);
    end else begin
      for (int i = 0; i < slots; i++) begin
        if (i > 0) text_q.push_back(CHAR_COLON);
        push_group();
      end
      if (tail) text_q.push_back(CHAR_COLON);
    end
    if (tail) begin
      for (int j = 0; j < 4; j++) begin
        if (j > 0) text_q.push_back(CHAR_DOT);
        s = $sformatf("%0d", ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 255));
        for (int n = 0; n < s.len(); n++) text_q.push_back(s[n]);
      end
    end
  endtask

  // Called at a falling edge; valid may still be high from the previous word.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{char_code: c, last_char: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int k = 0; k < text_q.size(); k++) send_char(text_q[k], k == text_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (addr_q.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int    sent;
    int    kind;
    int    pos;
    string s;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;
    mismatch_count = 0;
    stall_asked    = 0;
    send_idle_pct  = 16;
    recv_idle_pct  = 70;
    clear_parser();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      text_q = {};
      s = dir_rows[r].text;
      for (int n = 0; n < s.len(); n++) text_q.push_back(s[n]);
      given_q.push_back(dir_rows[r]);
      send_text();
    end
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 2) begin
        // Hold the result side off while addresses keep coming, so the
        // parser fills up and stalls its input.
        stall_asked <= stall_asked + 1;
        repeat (20) begin
          build_address();
          send_text();
        end
        wait_drained();
      end
      sent = 0;
      while (sent < CHARS_PER_PHASE) begin
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
          build_address();
          if (kind >= 6) begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 2))
              0: text_q[pos] = pick_char();
              1: if (text_q.size() > 1) text_q.delete(pos);
              default: text_q.insert(pos, pick_char());
            endcase
          end
        end else begin
          text_q = {};
          repeat ($urandom_range(1, 40)) text_q.push_back(pick_char());
        end
        send_text();
        sent += text_q.size();
      end
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
